// File: rtl/core/lruce_pkg.sv
// ----------------------------------------------------------------------------
// lruce_pkg
// Shared types and command codes for the LRU store with expiry.
// ----------------------------------------------------------------------------
package lruce_pkg;

    localparam int unsigned CMD_BITS = 2;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_PUT     = 2'd0,
        CMD_GET     = 2'd1,
        CMD_REMOVE  = 2'd2,
        CMD_CLEANUP = 2'd3
    } cmd_t;

    localparam logic [0:0] REG_CAPACITY = 1'b0;
    localparam logic [0:0] REG_EXPIRY   = 1'b1;

    typedef struct packed {
        logic [1:0]  command;
        logic [63:0] key;
        logic [31:0] now;
        logic [63:0] meta_in;
        logic        meta_valid;
    } req_t;

    typedef struct packed {
        logic        hit;
        logic        evicted;
        logic [63:0] evicted_key;
        logic [63:0] meta_out;
        logic [31:0] stamp_out;
        logic [4:0]  entries_held;
        logic        last;
    } rsp_t;

endpackage

// File: rtl/core/lru_cache_with_expiry.sv
// ----------------------------------------------------------------------------
// lru_cache_with_expiry
// Fully associative LRU store of tagged entries with age-based cleanup.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall carries one command beat (put, get, remove,
// cleanup). Output channel out_valid/out_stall carries result beats; every
// command ends with a beat whose last bit is set. Cleanup sends one beat per
// expired entry evicted from the least recent end, then the closing beat.
// A two-deep command queue decouples intake from the engine. Put, get and
// remove pass through dispatch, then associative match and rank update.
// Cleanup sends its beats from the cleanup state. A taken command is
// registered at dispatch, and its result beats come from the result register.
// Configuration: cfg_we writes cfg_index 0 (capacity) or 1 (expiry age);
// write only while idle. Reset empties the store, sets capacity 16 and
// expiry age 3600. When out_stall is high while a beat is presented, the result
// register holds and the engine waits; the queue keeps accepting until full.
module lru_cache_with_expiry
#(
    parameter int unsigned ENTRIES   = 16,
    parameter int unsigned KEY_BITS  = 64,
    parameter int unsigned TIME_BITS = 32
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  lruce_pkg::req_t in_data,
    output logic            out_valid,
    input  logic            out_stall,
    output lruce_pkg::rsp_t out_data,
    input  logic            cfg_we,
    input  logic [0:0]      cfg_index,
    input  logic [31:0]     cfg_data
);
    import lruce_pkg::*;

    logic [4:0]  cap_reg;
    logic [31:0] expiry_reg;
    logic        q_full;
    logic        q_empty;
    logic        q_take;
    req_t        q_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg    <= 5'd16;
            expiry_reg <= 32'd3600;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_CAPACITY)
                cap_reg <= cfg_data[4:0];
            else
                expiry_reg <= cfg_data;
        end
    end

    assign in_stall = q_full;

    lruce_fifo u_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (in_valid && !q_full),
        .wr_data (in_data),
        .full    (q_full),
        .rd_en   (q_take),
        .rd_data (q_data),
        .empty   (q_empty)
    );

    lruce_engine
    #(
        .ENTRIES   (ENTRIES),
        .KEY_BITS  (KEY_BITS),
        .TIME_BITS (TIME_BITS)
    )
    u_engine
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (!q_empty),
        .cmd_data       (q_data),
        .cmd_take       (q_take),
        .capacity_limit (cap_reg),
        .expiry_age     (expiry_reg),
        .valid          (out_valid),
        .stall          (out_stall),
        .result         (out_data)
    );

endmodule

// File: rtl/core/lruce_fifo.sv
// ----------------------------------------------------------------------------
// lruce_fifo
// Two-entry command queue between the front end and the execution engine.
// ----------------------------------------------------------------------------
module lruce_fifo
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  lruce_pkg::req_t wr_data,
    output logic           full,
    input  logic           rd_en,
    output lruce_pkg::req_t rd_data,
    output logic           empty
);
    import lruce_pkg::*;

    req_t       mem_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] count_reg;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign rd_data = mem_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (wr_en)
                wptr_reg <= ~wptr_reg;
            if (rd_en)
                rptr_reg <= ~rptr_reg;
            count_reg <= count_reg + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wptr_reg] <= wr_data;
    end

endmodule

// File: rtl/core/lruce_engine.sv
// ----------------------------------------------------------------------------
// lruce_engine
// Execution engine: holds the entries and ranks and runs each command.
// ----------------------------------------------------------------------------
module lruce_engine
#(
    parameter int unsigned ENTRIES   = 16,
    parameter int unsigned KEY_BITS  = 64,
    parameter int unsigned TIME_BITS = 32
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    input  lruce_pkg::req_t cmd_data,
    output logic            cmd_take,
    input  logic [4:0]      capacity_limit,
    input  logic [31:0]     expiry_age,
    output logic            valid,
    input  logic            stall,
    output lruce_pkg::rsp_t result
);
    import lruce_pkg::*;

    localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CW = $clog2(ENTRIES + 1);
    localparam int unsigned TW = (TIME_BITS < 32) ? TIME_BITS : 32;

    typedef enum logic [1:0] { ST_IDLE, ST_EXEC, ST_CLEAN } state_t;

    state_t            state_reg;
    req_t              cur_reg;
    logic [KEY_BITS-1:0] ekey_reg   [ENTRIES];
    logic [63:0]       emeta_reg    [ENTRIES];
    logic [TW-1:0]     estamp_reg   [ENTRIES];
    logic [ENTRIES-1:0] evalid_reg;
    logic [IW-1:0]     rank_reg     [ENTRIES];
    logic [CW-1:0]     occ_reg;
    logic [4:0]        clean_n_reg;
    logic              out_valid_reg;
    rsp_t              out_reg;

    // Match vectors, computed in parallel across all entries.
    logic [ENTRIES-1:0] hit_vec;
    logic [ENTRIES-1:0] old_vec;
    logic [IW-1:0]      hit_idx;
    logic [IW-1:0]      old_idx;
    logic [IW-1:0]      free_idx;
    logic               any_hit;
    logic               any_old;
    logic               any_free;
    logic [CW-1:0]      lim;
    logic [KEY_BITS-1:0] ckey;
    logic [TW-1:0]      cnow;
    logic [TW-1:0]      age;

    assign ckey = cur_reg.key[KEY_BITS-1:0];
    assign cnow = cur_reg.now[TW-1:0];

    always_comb
    begin
        hit_idx  = '0;
        old_idx  = '0;
        free_idx = '0;
        any_hit  = 1'b0;
        any_old  = 1'b0;
        any_free = 1'b0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            hit_vec[i] = evalid_reg[i] && (ekey_reg[i] == ckey);
            old_vec[i] = evalid_reg[i] && ({{(CW-IW){1'b0}}, rank_reg[i]} + 1'b1 == occ_reg);
            if (hit_vec[i])
            begin
                hit_idx = IW'(i);
                any_hit = 1'b1;
            end
            if (old_vec[i])
            begin
                old_idx = IW'(i);
                any_old = 1'b1;
            end
            if (!evalid_reg[i])
            begin
                free_idx = IW'(i);
                any_free = 1'b1;
            end
        end
        if (capacity_limit == 5'd0)
            lim = CW'(1);
        else if ({27'd0, capacity_limit} > ENTRIES)
            lim = CW'(ENTRIES);
        else
            lim = CW'(capacity_limit);
        age = cnow - estamp_reg[old_idx];
    end

    logic out_free;
    assign out_free = !out_valid_reg || !stall;
    assign valid    = out_valid_reg;
    assign result   = out_reg;
    assign cmd_take = (state_reg == ST_IDLE) && cmd_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            evalid_reg    <= '0;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
            clean_n_reg   <= '0;
            for (int i = 0; i < ENTRIES; i++)
                rank_reg[i] <= '0;
        end
        else
        begin
            if (out_valid_reg && !stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        cur_reg     <= cmd_data;
                        clean_n_reg <= '0;
                        state_reg   <= (cmd_t'(cmd_data.command) == CMD_CLEANUP)
                                       ? ST_CLEAN : ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_reg       <= '0;
                        out_reg.last  <= 1'b1;
                        state_reg     <= ST_IDLE;
                        case (cmd_t'(cur_reg.command))
                            CMD_PUT:
                            begin
                                out_reg.entries_held <= 5'(occ_reg);
                                if (cur_reg.meta_valid)
                                begin
                                    if (any_hit)
                                    begin
                                        for (int j = 0; j < ENTRIES; j++)
                                            if (evalid_reg[j] && rank_reg[j] < rank_reg[hit_idx])
                                                rank_reg[j] <= rank_reg[j] + 1'b1;
                                        rank_reg[hit_idx]   <= '0;
                                        emeta_reg[hit_idx]  <= cur_reg.meta_in;
                                        estamp_reg[hit_idx] <= cnow;
                                    end
                                    else if (occ_reg >= lim && any_old)
                                    begin
                                        // Evict the oldest and reuse its slot; everyone ages by one.
                                        out_reg.evicted     <= 1'b1;
                                        out_reg.evicted_key <= 64'(ekey_reg[old_idx]);
                                        for (int j = 0; j < ENTRIES; j++)
                                            if (evalid_reg[j])
                                                rank_reg[j] <= rank_reg[j] + 1'b1;
                                        rank_reg[old_idx]   <= '0;
                                        ekey_reg[old_idx]   <= ckey;
                                        emeta_reg[old_idx]  <= cur_reg.meta_in;
                                        estamp_reg[old_idx] <= cnow;
                                    end
                                    else if (any_free)
                                    begin
                                        for (int j = 0; j < ENTRIES; j++)
                                            if (evalid_reg[j])
                                                rank_reg[j] <= rank_reg[j] + 1'b1;
                                        rank_reg[free_idx]   <= '0;
                                        evalid_reg[free_idx] <= 1'b1;
                                        ekey_reg[free_idx]   <= ckey;
                                        emeta_reg[free_idx]  <= cur_reg.meta_in;
                                        estamp_reg[free_idx] <= cnow;
                                        occ_reg              <= occ_reg + 1'b1;
                                        out_reg.entries_held <= 5'(occ_reg + 1'b1);
                                    end
                                end
                            end
                            CMD_GET:
                            begin
                                out_reg.entries_held <= 5'(occ_reg);
                                if (any_hit)
                                begin
                                    for (int j = 0; j < ENTRIES; j++)
                                        if (evalid_reg[j] && rank_reg[j] < rank_reg[hit_idx])
                                            rank_reg[j] <= rank_reg[j] + 1'b1;
                                    rank_reg[hit_idx]  <= '0;
                                    out_reg.hit        <= 1'b1;
                                    out_reg.meta_out   <= emeta_reg[hit_idx];
                                    out_reg.stamp_out  <= 32'(estamp_reg[hit_idx]);
                                end
                            end
                            default:
                            begin
                                out_reg.entries_held <= 5'(occ_reg);
                                if (any_hit)
                                begin
                                    for (int j = 0; j < ENTRIES; j++)
                                        if (evalid_reg[j] && rank_reg[j] > rank_reg[hit_idx])
                                            rank_reg[j] <= rank_reg[j] - 1'b1;
                                    rank_reg[hit_idx]   <= '0;
                                    evalid_reg[hit_idx] <= 1'b0;
                                    occ_reg             <= occ_reg - 1'b1;
                                    out_reg.hit         <= 1'b1;
                                    out_reg.entries_held <= 5'(occ_reg - 1'b1);
                                end
                            end
                        endcase
                    end
                end
                ST_CLEAN:
                begin
                    // One eviction beat per cycle from the least recent end, while the output is not stalled.
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_reg       <= '0;
                        if (occ_reg != '0 && {27'd0, clean_n_reg} < ENTRIES && any_old
                            && 32'(age) > expiry_age)
                        begin
                            out_reg.evicted      <= 1'b1;
                            out_reg.evicted_key  <= 64'(ekey_reg[old_idx]);
                            out_reg.entries_held <= 5'(occ_reg - 1'b1);
                            evalid_reg[old_idx]  <= 1'b0;
                            rank_reg[old_idx]    <= '0;
                            occ_reg              <= occ_reg - 1'b1;
                            clean_n_reg          <= clean_n_reg + 1'b1;
                        end
                        else
                        begin
                            out_reg.entries_held <= 5'(occ_reg);
                            out_reg.last         <= 1'b1;
                            state_reg            <= ST_IDLE;
                        end
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives put, get, remove and cleanup beats into the LRU store with expiry and
// compares every result beat against a behavioral LRU store kept in step.
// ----------------------------------------------------------------------------
module tb_top;
    import lruce_pkg::*;

    localparam int NSLOT = 16;
    localparam int CYCLE_LIMIT = 400000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    req_t        in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    rsp_t        out_data;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = REG_CAPACITY;
    logic [31:0] cfg_data = '0;

    lru_cache_with_expiry uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Shadow copy of the store.
    logic [63:0] sh_key [NSLOT];
    logic [63:0] sh_meta [NSLOT];
    logic [31:0] sh_stamp [NSLOT];
    logic        sh_valid [NSLOT];
    int          sh_rank [NSLOT];
    int          sh_count;
    logic [4:0]  sh_capacity;
    logic [31:0] sh_expiry;

    rsp_t pending_rsp [$];
    int   mismatches = 0;
    int   cycles = 0;
    bit   quiet = 0;
    logic [63:0] used_keys [$];

    function automatic int slot_of(logic [63:0] k);
        for (int i = 0; i < NSLOT; i++)
            if (sh_valid[i] && sh_key[i] == k) return i;
        return -1;
    endfunction

    function automatic int oldest_slot();
        for (int i = 0; i < NSLOT; i++)
            if (sh_valid[i] && sh_rank[i] + 1 == sh_count) return i;
        return -1;
    endfunction

    function automatic void drop_slot(int s);
        for (int j = 0; j < NSLOT; j++)
            if (sh_valid[j] && sh_rank[j] > sh_rank[s]) sh_rank[j]--;
        sh_valid[s] = 1'b0;
        sh_rank[s] = 0;
        sh_count--;
    endfunction

    function automatic void promote_slot(int s);
        for (int j = 0; j < NSLOT; j++)
            if (sh_valid[j] && sh_rank[j] < sh_rank[s]) sh_rank[j]++;
        sh_rank[s] = 0;
    endfunction

    function automatic rsp_t make_rsp(logic h, logic ev, logic [63:0] ek,
                                      logic [63:0] m, logic [31:0] st, logic l);
        rsp_t r;
        r.hit = h; r.evicted = ev; r.evicted_key = ek; r.meta_out = m;
        r.stamp_out = st; r.entries_held = sh_count[4:0]; r.last = l;
        return r;
    endfunction

    // Advances the shadow store by one command and queues its result beats.
    function automatic void predict_lru(req_t q);
        int s, o, lim, n;
        logic ev;
        logic [63:0] ek;
        logic [31:0] age;
        n = 0;
        case (cmd_t'(q.command))
            CMD_PUT:
            begin
                ev = 1'b0; ek = '0;
                if (q.meta_valid)
                begin
                    lim = sh_capacity;
                    if (lim < 1) lim = 1;
                    if (lim > NSLOT) lim = NSLOT;
                    s = slot_of(q.key);
                    if (s >= 0) promote_slot(s);
                    else
                    begin
                        if (sh_count >= lim)
                        begin
                            o = oldest_slot();
                            if (o >= 0)
                            begin
                                ev = 1'b1; ek = sh_key[o]; drop_slot(o);
                            end
                        end
                        s = -1;
                        for (int i = NSLOT - 1; i >= 0; i--)
                            if (!sh_valid[i]) s = i;
                        if (s >= 0)
                        begin
                            for (int j = 0; j < NSLOT; j++)
                                if (sh_valid[j]) sh_rank[j]++;
                            sh_valid[s] = 1'b1; sh_rank[s] = 0; sh_count++;
                        end
                    end
                    if (s >= 0)
                    begin
                        sh_key[s] = q.key; sh_meta[s] = q.meta_in; sh_stamp[s] = q.now;
                    end
                end
                pending_rsp.push_back(make_rsp(0, ev, ek, '0, '0, 1));
            end
            CMD_GET:
            begin
                s = slot_of(q.key);
                if (s < 0) pending_rsp.push_back(make_rsp(0, 0, '0, '0, '0, 1));
                else
                begin
                    promote_slot(s);
                    pending_rsp.push_back(make_rsp(1, 0, '0, sh_meta[s], sh_stamp[s], 1));
                end
            end
            CMD_REMOVE:
            begin
                s = slot_of(q.key);
                if (s >= 0) drop_slot(s);
                pending_rsp.push_back(make_rsp(s >= 0, 0, '0, '0, '0, 1));
            end
            default:
            begin
                while (sh_count > 0 && n < NSLOT)
                begin
                    o = oldest_slot();
                    if (o < 0) break;
                    age = q.now - sh_stamp[o];
                    if (age <= sh_expiry) break;
                    ek = sh_key[o];
                    drop_slot(o);
                    pending_rsp.push_back(make_rsp(0, 1, ek, '0, '0, 0));
                    n++;
                end
                pending_rsp.push_back(make_rsp(0, 0, '0, '0, '0, 1));
            end
        endcase
    endfunction

    // Result checking at the rising edge.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %p", out_data);
            end
            else
            begin
                if (out_data !== pending_rsp[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %p got %p",
                                 pending_rsp[0], out_data);
                end
                void'(pending_rsp.pop_front());
            end
        end
        if (cycles > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver stall, with a quiet stretch.
    always @(negedge clk)
        out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 29);

    // The input side is driven with blocking writes at the falling edge, so
    // back-to-back beats never schedule two updates of in_valid in one step.
    task automatic send_cmd(cmd_t c, logic [63:0] k, logic [31:0] t,
                            logic [63:0] m, logic mv);
        req_t q;
        q.command = c; q.key = k; q.now = t; q.meta_in = m; q.meta_valid = mv;
        while (!quiet && $urandom_range(99) < 29)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data = q;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_lru(q);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic drain();
        while (pending_rsp.size() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [31:0] v);
        drain();
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
        if (idx == REG_CAPACITY) sh_capacity = v[4:0];
        else sh_expiry = v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [63:0] pick_key();
        if (used_keys.size() != 0 && $urandom_range(3) != 0)
            return used_keys[$urandom_range(used_keys.size() - 1)];
        pick_key = {$urandom(), $urandom()};
        if ($urandom_range(7) == 0) pick_key = $urandom_range(1) ? '1 : '0;
        used_keys.push_back(pick_key);
    endfunction

    typedef struct {
        cmd_t        c;
        logic [63:0] k;
        logic [31:0] t;
        logic [63:0] m;
        logic        mv;
    } row_t;

    row_t directed_rows [] = '{
        '{CMD_GET,     64'h0,  32'd0,     64'h0,  1'b1},
        '{CMD_REMOVE,  64'h0,  32'd0,     64'h0,  1'b0},
        '{CMD_CLEANUP, 64'h0,  32'hFFFFFFFF, 64'h0, 1'b0},
        '{CMD_PUT,     64'h0,  32'd0,     '1,     1'b1},
        '{CMD_PUT,     '1,     32'hFFFFFFFF, 64'h0, 1'b1},
        '{CMD_PUT,     64'h5,  32'd10,    64'h55, 1'b0},
        '{CMD_GET,     64'h5,  32'd10,    64'h0,  1'b0},
        '{CMD_GET,     '1,     32'd0,     64'h0,  1'b0},
        '{CMD_GET,     64'h0,  32'd0,     64'h0,  1'b0},
        '{CMD_PUT,     64'h0,  32'd100,   64'hA5, 1'b1},
        '{CMD_PUT,     64'h7,  32'd200,   64'h77, 1'b1},
        '{CMD_REMOVE,  '1,     32'd0,     64'h0,  1'b1},
        '{CMD_REMOVE,  '1,     32'd0,     64'h0,  1'b1},
        '{CMD_CLEANUP, 64'h0,  32'd3000,  64'h0,  1'b0},
        '{CMD_CLEANUP, 64'h0,  32'd4000,  64'h0,  1'b0},
        '{CMD_GET,     64'h7,  32'd0,     64'h0,  1'b1}
    };

    initial
    begin
        sh_count = 0; sh_capacity = 5'd16; sh_expiry = 32'd3600;
        for (int i = 0; i < NSLOT; i++)
        begin
            sh_valid[i] = 1'b0; sh_rank[i] = 0;
            sh_key[i] = '0; sh_meta[i] = '0; sh_stamp[i] = '0;
        end
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // First beats after reset have results known at a glance.
        send_cmd(CMD_GET, 64'h1, 32'd0, 64'h0, 1'b1);
        drain();
        foreach (directed_rows[i])
            send_cmd(directed_rows[i].c, directed_rows[i].k, directed_rows[i].t,
                     directed_rows[i].m, directed_rows[i].mv);

        // Capacity one, then zero (acts as one), then above the store size.
        write_reg(REG_CAPACITY, 32'd1);
        write_reg(REG_EXPIRY, 32'd0);
        for (int i = 0; i < 6; i++)
            send_cmd(CMD_PUT, 64'(i), 32'(i), 64'(i * 3), 1'b1);
        send_cmd(CMD_CLEANUP, '0, 32'd0, '0, 1'b0);
        write_reg(REG_CAPACITY, 32'd0);
        send_cmd(CMD_PUT, 64'h9, 32'd1, 64'h1, 1'b1);
        send_cmd(CMD_PUT, 64'hA, 32'd1, 64'h1, 1'b1);
        write_reg(REG_CAPACITY, 32'd31);
        write_reg(REG_EXPIRY, 32'hFFFFFFFF);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                1: begin write_reg(REG_CAPACITY, 32'd4); write_reg(REG_EXPIRY, 32'd50); end
                2: begin write_reg(REG_CAPACITY, 32'd16); write_reg(REG_EXPIRY, 32'd20); end
                3: begin write_reg(REG_CAPACITY, 32'd2); write_reg(REG_EXPIRY, 32'd3600); end
                default: ;
            endcase
            quiet = (phase == 2);
            for (int i = 0; i < 24; i++)
            begin
                logic [31:0] tnow;
                int r;
                tnow = (phase == 3) ? $urandom() : 32'($urandom_range(200));
                r = $urandom_range(99);
                if (r < 45)
                    send_cmd(CMD_PUT, pick_key(), tnow, {$urandom(), $urandom()},
                             $urandom_range(9) != 0);
                else if (r < 75)
                    send_cmd(CMD_GET, pick_key(), tnow, {$urandom(), $urandom()},
                             1'($urandom_range(1)));
                else if (r < 90)
                    send_cmd(CMD_REMOVE, pick_key(), tnow, '0, 1'($urandom_range(1)));
                else
                    send_cmd(CMD_CLEANUP, pick_key(), tnow, '0, 1'($urandom_range(1)));
                if (i == 16 && phase == 1)
                    while (pending_rsp.size() != 0) @(negedge clk);
            end
        end
        quiet = 0;
        drain();
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
